// File: hw/rtl/smpb_pkg.sv
// Package for the sorted min/max patch balancer.
// Holds widths, payload structs, store entry type and the sequencer states.
// No dependencies.
package smpb_pkg;

  localparam int unsigned MaxPatches = 64;
  localparam int unsigned CountW     = 32;
  localparam int unsigned PatchIdW   = 6;
  localparam int unsigned SlotW      = $clog2(MaxPatches);
  localparam int unsigned LoadW      = $clog2(MaxPatches + 1);
  localparam int unsigned ProcsW     = 13;
  localparam int unsigned ProcIdxW   = 12;

  typedef struct packed {
    logic [CountW-1:0]   particle_count;
    logic [PatchIdW-1:0] patch_id;
    logic                last_patch;
  } smpb_in_t;

  typedef struct packed {
    logic [PatchIdW-1:0] out_patch_id;
    logic [ProcIdxW-1:0] proc_index;
    logic                last_result;
  } smpb_out_t;

  typedef struct packed {
    logic [CountW-1:0]   count;
    logic [PatchIdW-1:0] id;
  } smpb_entry_t;

  localparam int unsigned EntryW = $bits(smpb_entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_PLACE,
    ST_DECIDE,
    ST_HI,
    ST_LO_RD,
    ST_LO
  } smpb_state_e;

endpackage

// File: hw/rtl/smpb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smpb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hw/rtl/sorted_minmax_patch_balancer_core.sv
// Sorted min/max patch balancer: top level with insertion and balancing sequencer.
// Depends on smpb_pkg and smpb_ram.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one patch per
//   transaction: particle count, patch id and a last flag. Patches are kept in
//   a RAM sorted by count, ascending; equal counts stay in arrival order.
//   Insertion walks the RAM one entry per cycle, moving each stored entry with a
//   larger count up one slot; an item that arrives while the store is full is
//   dropped. An item with the last flag starts balancing. Each assignment is one
//   output transaction (out_valid_o / out_stall_i / out_data_o). A single take
//   passes ST_DECIDE and ST_HI, a heaviest/lightest pair ST_DECIDE, ST_HI,
//   ST_LO_RD and ST_LO, as each entry comes through the registered RAM read port.
//   The final assignment carries last_result. The input side is stalled until
//   the run ends. A receiver stall holds the output register and pauses the
//   sequencer. The configuration channel writes num_procs (0 acts as 1); the user
//   must do so only while idle, as the block itself does not enforce this.
//   Reset empties the store, sets num_procs to 1 and drops any pending output.
module sorted_minmax_patch_balancer_core
  import smpb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  smpb_in_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output smpb_out_t         out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [ProcsW-1:0] cfg_data_i
);

  smpb_state_e       state_q, state_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [PatchIdW-1:0] id_q, id_d;
  logic              last_q, last_d;
  logic [SlotW-1:0]  pos_q, pos_d;
  logic [LoadW-1:0]  loaded_q, loaded_d;
  logic [LoadW-1:0]  left_q, left_d;
  logic [SlotW-1:0]  lo_q, lo_d;
  logic [SlotW-1:0]  hi_q, hi_d;
  logic [ProcsW-1:0] proc_q, proc_d;
  logic              pair_q, pair_d;
  logic [ProcsW-1:0] num_procs_q;
  logic              out_valid_q, out_valid_d;
  smpb_out_t         out_data_q, out_data_d;

  logic              wr_en;
  logic [SlotW-1:0]  wr_addr;
  smpb_entry_t       wr_entry;
  logic [SlotW-1:0]  rd_addr;
  logic [EntryW-1:0] rd_raw;
  smpb_entry_t       rd_entry;

  logic              in_accept;
  logic              can_load;
  logic [ProcsW-1:0] procs_eff;
  logic [ProcsW-1:0] proc_next;
  logic [ProcsW:0]   two_rem;
  logic [LoadW-1:0]  loaded_inc;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign can_load   = !out_valid_q || !out_stall_i;
  assign procs_eff  = (num_procs_q == '0) ? ProcsW'(1) : num_procs_q;
  assign proc_next  = (proc_q + ProcsW'(1) == procs_eff) ? '0 : proc_q + ProcsW'(1);
  assign two_rem    = {procs_eff - proc_q, 1'b0};
  assign loaded_inc = loaded_q + LoadW'(1);
  assign rd_entry   = smpb_entry_t'(rd_raw);

  smpb_ram #(
    .Width (EntryW),
    .Depth (MaxPatches)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_entry),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_raw)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      loaded_q    <= '0;
      num_procs_q <= ProcsW'(1);
      out_valid_q <= 1'b0;
      proc_q      <= '0;
      left_q      <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
    end else begin
      state_q     <= state_d;
      loaded_q    <= loaded_d;
      out_valid_q <= out_valid_d;
      proc_q      <= proc_d;
      left_q      <= left_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      if (cfg_valid_i && cfg_ready_o) begin
        num_procs_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q      <= cnt_d;
    id_q       <= id_d;
    last_q     <= last_d;
    pos_q      <= pos_d;
    pair_q     <= pair_d;
    out_data_q <= out_data_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    id_d        = id_q;
    last_d      = last_q;
    pos_d       = pos_q;
    loaded_d    = loaded_q;
    left_d      = left_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    proc_d      = proc_q;
    pair_d      = pair_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    wr_en       = 1'b0;
    wr_addr     = pos_q;
    wr_entry    = rd_entry;
    rd_addr     = hi_q;

    case (state_q)
      ST_IDLE: begin
        rd_addr = loaded_q[SlotW-1:0] - SlotW'(1);
        if (in_accept) begin
          cnt_d  = in_data_i.particle_count;
          id_d   = in_data_i.patch_id;
          last_d = in_data_i.last_patch;
          pos_d  = loaded_q[SlotW-1:0];
          if (loaded_q < LoadW'(MaxPatches)) begin
            state_d = (loaded_q == '0) ? ST_PLACE : ST_SHIFT;
          end else if (in_data_i.last_patch) begin
            left_d   = loaded_q;
            hi_d     = loaded_q[SlotW-1:0] - SlotW'(1);
            lo_d     = '0;
            proc_d   = '0;
            loaded_d = '0;
            state_d  = ST_DECIDE;
          end
        end
      end

      ST_SHIFT: begin
        rd_addr = pos_q - SlotW'(2);
        if (rd_entry.count > cnt_q) begin
          wr_en   = 1'b1;
          wr_addr = pos_q;
          pos_d   = pos_q - SlotW'(1);
          if (pos_q == SlotW'(1)) begin
            state_d = ST_PLACE;
          end
        end else begin
          state_d = ST_PLACE;
        end
      end

      ST_PLACE: begin
        wr_en          = 1'b1;
        wr_addr        = pos_q;
        wr_entry.count = cnt_q;
        wr_entry.id    = id_q;
        if (last_q) begin
          left_d   = loaded_inc;
          hi_d     = loaded_inc[SlotW-1:0] - SlotW'(1);
          lo_d     = '0;
          proc_d   = '0;
          loaded_d = '0;
          state_d  = ST_DECIDE;
        end else begin
          loaded_d = loaded_inc;
          state_d  = ST_IDLE;
        end
      end

      ST_DECIDE: begin
        rd_addr = hi_q;
        pair_d  = {{(ProcsW + 1 - LoadW){1'b0}}, left_q} >= two_rem;
        state_d = ST_HI;
      end

      ST_HI: begin
        rd_addr = hi_q;
        if (can_load) begin
          out_valid_d             = 1'b1;
          out_data_d.out_patch_id = rd_entry.id;
          out_data_d.proc_index   = proc_q[ProcIdxW-1:0];
          out_data_d.last_result  = !pair_q && (left_q == LoadW'(1));
          if (pair_q) begin
            state_d = ST_LO_RD;
          end else begin
            if (hi_q != '0) begin
              hi_d = hi_q - SlotW'(1);
            end
            left_d  = left_q - LoadW'(1);
            proc_d  = proc_next;
            state_d = (left_q == LoadW'(1)) ? ST_IDLE : ST_DECIDE;
          end
        end
      end

      ST_LO_RD: begin
        rd_addr = lo_q;
        state_d = ST_LO;
      end

      ST_LO: begin
        rd_addr = lo_q;
        if (can_load) begin
          out_valid_d             = 1'b1;
          out_data_d.out_patch_id = rd_entry.id;
          out_data_d.proc_index   = proc_q[ProcIdxW-1:0];
          out_data_d.last_result  = (left_q == LoadW'(2));
          hi_d    = hi_q - SlotW'(1);
          lo_d    = lo_q + SlotW'(1);
          left_d  = left_q - LoadW'(2);
          proc_d  = proc_next;
          state_d = (left_q == LoadW'(2)) ? ST_IDLE : ST_DECIDE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_loaded_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loaded_q <= LoadW'(MaxPatches))
    else $error("store fill count exceeds capacity");

  a_left_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE || state_q == ST_HI || state_q == ST_LO_RD || state_q == ST_LO)
    |-> left_q != '0)
    else $error("balancing with no patch left");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LO) |-> (lo_q < hi_q) && (left_q >= LoadW'(2)))
    else $error("pair take without two distinct patches");

  a_proc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE || state_q == ST_HI) |-> proc_q < procs_eff)
    else $error("processor index out of range");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_d && !(out_valid_q && out_stall_i) && out_data_d.last_result)
    |=> state_q == ST_IDLE && loaded_q == '0)
    else $error("final assignment did not end the run");

endmodule

// File: sim/sorted_minmax_patch_balancer_core_tb.sv
// Testbench for sorted_minmax_patch_balancer_core: random and directed patch sets
// checked by a scoreboard that sorts the set and predicts every assignment.
// Depends on smpb_pkg and the core RTL.
`timescale 1ns / 1ps

module sorted_minmax_patch_balancer_core_tb
  import smpb_pkg::*;
();

  localparam int CycleLimit = 400000;
  localparam int IdlePause  = 80;
  localparam int HoldCycles = 400;
  localparam int RandItems  = 86;

  class balance_scoreboard;
    logic [CountW-1:0]   count_sorted[MaxPatches];
    logic [PatchIdW-1:0] id_sorted[MaxPatches];
    int                  stored;
    logic [ProcsW-1:0]   num_procs;
    smpb_out_t           pending_assignments[$];
    int                  errors;

    function new();
      stored    = 0;
      num_procs = 1;
      errors    = 0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 30) $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    function void set_procs(logic [ProcsW-1:0] v);
      num_procs = v;
    endfunction

    function int pending();
      return pending_assignments.size();
    endfunction

    function void add_assignment(logic [PatchIdW-1:0] id, int proc);
      smpb_out_t r;
      r.out_patch_id = id;
      r.proc_index   = proc[ProcIdxW-1:0];
      r.last_result  = 1'b0;
      pending_assignments = {pending_assignments, r};
    endfunction

    function void note_patch(smpb_in_t it);
      int pos;
      int procs;
      int left;
      int lo;
      int hi;
      int i;
      smpb_out_t tail;
      if (stored < MaxPatches) begin
        pos = stored;
        while (pos > 0 && count_sorted[pos-1] > it.particle_count) begin
          count_sorted[pos] = count_sorted[pos-1];
          id_sorted[pos]    = id_sorted[pos-1];
          pos--;
        end
        count_sorted[pos] = it.particle_count;
        id_sorted[pos]    = it.patch_id;
        stored++;
      end
      if (!it.last_patch) return;
      procs = (num_procs == 0) ? 1 : int'(num_procs);
      left  = stored;
      lo    = 0;
      hi    = stored - 1;
      while (left > 0) begin
        for (i = 0; i < procs && left > 0; i++) begin
          if (left >= 2 * (procs - i)) begin
            add_assignment(id_sorted[hi], i);
            add_assignment(id_sorted[lo], i);
            hi--;
            lo++;
            left -= 2;
          end else begin
            add_assignment(id_sorted[hi], i);
            if (hi > 0) hi--;
            left--;
          end
        end
      end
      tail = pending_assignments[pending_assignments.size()-1];
      tail.last_result = 1'b1;
      pending_assignments[pending_assignments.size()-1] = tail;
      stored = 0;
    endfunction

    task check_assignment(smpb_out_t got);
      smpb_out_t want;
      if (pending_assignments.size() == 0) begin
        report($sformatf("unexpected assignment id=%0d proc=%0d last=%0b",
                         got.out_patch_id, got.proc_index, got.last_result));
        return;
      end
      want = pending_assignments.pop_front();
      if (got.out_patch_id !== want.out_patch_id)
        report($sformatf("out_patch_id got %0d want %0d", got.out_patch_id, want.out_patch_id));
      if (got.proc_index !== want.proc_index)
        report($sformatf("proc_index got %0d want %0d", got.proc_index, want.proc_index));
      if (got.last_result !== want.last_result)
        report($sformatf("last_result got %0b want %0b", got.last_result, want.last_result));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  smpb_in_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  smpb_out_t         out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [ProcsW-1:0] cfg_data = '0;

  balance_scoreboard sb = new();

  int  cycles = 0;
  int  rand_items = 0;
  bit  in_quiet = 1'b0;
  bit  out_quiet = 1'b0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  int  stall_left = 0;
  int  stall_roll;

  sorted_minmax_patch_balancer_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_assignment(out_data);
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (hold_req && out_valid) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles - 1;
        out_stall = 1'b1;
      end else if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        stall_roll = $urandom_range(0, 99);
        if (!out_quiet && stall_roll < 25) begin
          stall_left = (stall_roll < 22) ? $urandom_range(0, 2) : $urandom_range(10, 40);
          out_stall  = 1'b1;
        end else begin
          out_stall = 1'b0;
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (in_quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [CountW-1:0] pick_count();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 7);
      4:          return '0;
      5:          return '1;
      default:    return $urandom;
    endcase
  endfunction

  function automatic logic [ProcsW-1:0] pick_procs();
    case ($urandom_range(0, 7))
      0:       return ProcsW'(0);
      1:       return ProcsW'(1);
      2:       return ProcsW'(2);
      3:       return ProcsW'($urandom_range(3, 16));
      4:       return ProcsW'($urandom_range(17, 70));
      5:       return ProcsW'(4096);
      6:       return ProcsW'(8191);
      default: return ProcsW'($urandom_range(71, 8191));
    endcase
  endfunction

  task automatic send_item(input smpb_in_t item);
    int gap;
    in_valid = 1'b1;
    in_data  = item;
    do @(posedge clk); while (in_stall);
    sb.note_patch(item);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_patch(input logic [CountW-1:0] cnt, input logic [PatchIdW-1:0] id,
                            input logic last);
    smpb_in_t item;
    item.particle_count = cnt;
    item.patch_id       = id;
    item.last_patch     = last;
    send_item(item);
  endtask

  task automatic send_random_set(input int n);
    int j;
    for (j = 0; j < n; j++) begin
      send_patch(pick_count(), PatchIdW'($urandom_range(0, 63)), j == n - 1);
      rand_items++;
    end
  endtask

  task automatic write_num_procs(input logic [ProcsW-1:0] v);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (IdlePause) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_procs(v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    int set_no;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    repeat (2) @(negedge clk);

    send_patch('1, 63, 1'b1);

    write_num_procs(0);
    send_patch(5, 1, 1'b0);
    send_patch(0, 2, 1'b0);
    send_patch(5, 1, 1'b0);
    send_patch('1, 63, 1'b0);
    send_patch(5, 0, 1'b1);

    write_num_procs(3);
    send_patch(9, 10, 1'b0);
    send_patch(3, 11, 1'b0);
    send_patch(3, 12, 1'b0);
    send_patch(100, 13, 1'b0);
    send_patch(0, 14, 1'b0);
    send_patch(7, 15, 1'b0);
    send_patch(1, 16, 1'b1);

    write_num_procs(8191);
    send_patch(32'h8000_0000, 20, 1'b0);
    send_patch(32'h7FFF_FFFF, 21, 1'b0);
    send_patch(0, 22, 1'b0);
    send_patch('1, 23, 1'b1);

    write_num_procs(2);
    send_patch(4, 30, 1'b0);
    send_patch(4, 31, 1'b0);
    send_patch(2, 32, 1'b0);
    send_patch(8, 33, 1'b0);
    send_patch(1, 34, 1'b1);

    write_num_procs(4096);
    send_patch(6, 40, 1'b0);
    send_patch(6, 41, 1'b1);

    write_num_procs(pick_procs());
    send_random_set(MaxPatches + $urandom_range(1, 3));

    set_no = 0;
    while (rand_items < RandItems) begin
      in_quiet  = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      if (set_no == 1) hold_req = 1'b1;
      else if (set_no != 2 && $urandom_range(0, 1)) write_num_procs(pick_procs());
      send_random_set($urandom_range(1, 12));
      set_no++;
    end
    in_valid = 1'b0;

    while (sb.pending() != 0) @(negedge clk);
    repeat (IdlePause + 20) @(negedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d assignments never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/smpb_pkg.sv
hw/rtl/smpb_ram.sv
hw/rtl/sorted_minmax_patch_balancer_core.sv
sim/sorted_minmax_patch_balancer_core_tb.sv
